// ===== design/alu8_pkg.sv =====
// Shared types and constants for the 8-bit CPU ALU with flags.
// Holds the opcode codes, flag bit positions and the input and result word layouts.
// Depends on nothing; the top level and alu8_core refer to it by scoped names.
package alu8_pkg;

  localparam int unsigned OpW = 5;

  localparam logic [OpW-1:0] OP_ADD   = 5'd0;
  localparam logic [OpW-1:0] OP_ADC   = 5'd1;
  localparam logic [OpW-1:0] OP_SUB   = 5'd2;
  localparam logic [OpW-1:0] OP_SBC   = 5'd3;
  localparam logic [OpW-1:0] OP_AND   = 5'd4;
  localparam logic [OpW-1:0] OP_OR    = 5'd5;
  localparam logic [OpW-1:0] OP_XOR   = 5'd6;
  localparam logic [OpW-1:0] OP_CP    = 5'd7;
  localparam logic [OpW-1:0] OP_INC   = 5'd8;
  localparam logic [OpW-1:0] OP_DEC   = 5'd9;
  localparam logic [OpW-1:0] OP_RLC   = 5'd10;
  localparam logic [OpW-1:0] OP_RRC   = 5'd11;
  localparam logic [OpW-1:0] OP_RL    = 5'd12;
  localparam logic [OpW-1:0] OP_RR    = 5'd13;
  localparam logic [OpW-1:0] OP_SLA   = 5'd14;
  localparam logic [OpW-1:0] OP_SRA   = 5'd15;
  localparam logic [OpW-1:0] OP_SRL   = 5'd16;
  localparam logic [OpW-1:0] OP_SWAP  = 5'd17;
  localparam logic [OpW-1:0] OP_BIT   = 5'd18;
  localparam logic [OpW-1:0] OP_RES   = 5'd19;
  localparam logic [OpW-1:0] OP_SET   = 5'd20;
  localparam logic [OpW-1:0] OP_DAA   = 5'd21;
  localparam logic [OpW-1:0] OP_CPL   = 5'd22;
  localparam logic [OpW-1:0] OP_CCF   = 5'd23;
  localparam logic [OpW-1:0] OP_SCF   = 5'd24;
  localparam logic [OpW-1:0] OP_ADD16 = 5'd25;
  localparam logic [OpW-1:0] OP_INC16 = 5'd26;
  localparam logic [OpW-1:0] OP_DEC16 = 5'd27;

  // Flag bit positions inside the packed Z N H C nibble.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust corrections and the BCD upper limit.
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [3:0] DAA_NIB_LIMIT = 4'h9;

  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic [15:0]    a_value;
    logic [15:0]    b_value;
    logic [2:0]     bit_index;
    logic [3:0]     flags_in;
  } in_word_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        writes_result;
  } out_word_t;

endpackage

// ===== design/alu8_stream_if.sv =====
// Valid/ready stream channel used for both the input and the result side of the ALU.
// The payload type is handed in as a type parameter; depends on nothing else.
interface alu8_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/eight_bit_cpu_alu_with_flags_unit.sv =====
// Top level of the 8-bit CPU ALU with flags: input register, datapath, result register.
// Depends on alu8_pkg, alu8_stream_if and alu8_core.
//
//   channel  dir  modport   word type             contents
//   in_ch    in   sink      alu8_pkg::in_word_t   opcode, a_value, b_value, bit_index, flags_in
//   out_ch   out  source    alu8_pkg::out_word_t  result, flags_out, writes_result
//
// Every accepted word gives exactly one result word. It is held in the input register
// and then in the result register, with the single-pass datapath between them.
// One word is accepted per cycle unless out_ch stalls; the two register stages set the rate.
// Reset (rst_n low at a rising edge) empties both stages; payloads are not cleared.
// A stall on out_ch holds the result register, then the input register, and only
// when both are full does in_ch.ready fall.
module eight_bit_cpu_alu_with_flags_unit (
  input logic clk,
  input logic rst_n,
  alu8_stream_if.sink   in_ch,
  alu8_stream_if.source out_ch
);

  // Input stage: holds the operand word while the datapath works on it.
  logic                in_v_r;
  logic                in_v_nxt;
  alu8_pkg::in_word_t  in_word_r;

  // Result stage: holds the finished word until the consumer takes it.
  logic                out_v_r;
  logic                out_v_nxt;
  alu8_pkg::out_word_t out_word_r;
  alu8_pkg::out_word_t core_word;

  logic out_take;
  logic in_move;
  logic in_take;

  alu8_core u_core (
    .in_word  (in_word_r),
    .out_word (core_word)
  );

  // The result stage can load whenever it is empty or is being emptied this cycle.
  assign out_take = !out_v_r || out_ch.ready;
  // The input stage moves forward into the result stage.
  assign in_move  = in_v_r && out_take;
  // The input stage can accept when it is empty or its word is moving on.
  assign in_ch.ready = !in_v_r || in_move;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (in_move) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_take) begin
      out_v_nxt = in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_ch.data;
    end
    if (in_move) begin
      out_word_r <= core_word;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_word_r;

  // An accepted word must occupy the input stage in the next cycle.
  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_v_r)
    else $error("accepted word did not reach the input stage");

  // A word leaving the input stage must show up as a valid result next cycle.
  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_move |=> out_v_r)
    else $error("word lost between input and result stage");

  // Back-pressure only when both stages are full and the result side is stalled.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  // Operations that do not write back always present a cleared result.
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_word_r.writes_result) |-> (out_word_r.result == 16'd0))
    else $error("non-writing operation produced a nonzero result");

endmodule

// ===== design/alu8_core.sv =====
// Single-pass datapath of the ALU: computes result, flags and write-back for one word.
// Purely combinational; depends on alu8_pkg for opcodes, flag positions and word types.
module alu8_core (
  input  alu8_pkg::in_word_t  in_word,
  output alu8_pkg::out_word_t out_word
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [3:0]  f;
  logic        ni;
  logic        hi;
  logic        ci;
  logic        cy;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  r8;
  logic [15:0] r;
  logic [3:0]  fo;
  logic        wr;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_adj;
  logic        daa_c;
  logic [16:0] sum17;
  logic [12:0] hsum13;

  assign a8 = in_word.a_value[7:0];
  assign b8 = in_word.b_value[7:0];
  assign f  = in_word.flags_in;
  assign ni = f[alu8_pkg::FLAG_N];
  assign hi = f[alu8_pkg::FLAG_H];
  assign ci = f[alu8_pkg::FLAG_C];

  // The adder and subtractor take carry-in only in the with-carry forms.
  assign cy = ci & ((in_word.opcode == alu8_pkg::OP_ADC) ||
                    (in_word.opcode == alu8_pkg::OP_SBC));

  assign sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cy};
  assign hsum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cy};
  // A set top bit means the subtraction borrowed.
  assign diff9  = {1'b0, a8} - {1'b0, b8} - {8'd0, cy};
  assign hdiff5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cy};

  assign bit_mask = 8'd1 << in_word.bit_index;

  assign sum17  = {1'b0, in_word.a_value} + {1'b0, in_word.b_value};
  assign hsum13 = {1'b0, in_word.a_value[11:0]} + {1'b0, in_word.b_value[11:0]};

  // Decimal adjust: after a subtraction only undo the flagged corrections,
  // after an addition also correct digits that went past nine.
  always_comb begin
    daa_adj = 8'd0;
    daa_c   = ci;
    if (ni) begin
      if (ci) daa_adj = daa_adj | alu8_pkg::DAA_HI_ADJ;
      if (hi) daa_adj = daa_adj | alu8_pkg::DAA_LO_ADJ;
    end else begin
      if (ci || (a8 > alu8_pkg::DAA_LIMIT)) begin
        daa_adj = daa_adj | alu8_pkg::DAA_HI_ADJ;
        daa_c   = 1'b1;
      end
      if (hi || (a8[3:0] > alu8_pkg::DAA_NIB_LIMIT)) daa_adj = daa_adj | alu8_pkg::DAA_LO_ADJ;
    end
  end

  always_comb begin
    r8 = 8'd0;
    r  = 16'd0;
    fo = f;
    wr = 1'b1;
    case (in_word.opcode)
      alu8_pkg::OP_ADD, alu8_pkg::OP_ADC: begin
        r8 = sum9[7:0];
        fo = {(r8 == 8'd0), 1'b0, hsum5[4], sum9[8]};
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_SBC: begin
        r8 = diff9[7:0];
        fo = {(r8 == 8'd0), 1'b1, hdiff5[4], diff9[8]};
      end
      alu8_pkg::OP_CP: begin
        fo = {(diff9[7:0] == 8'd0), 1'b1, hdiff5[4], diff9[8]};
        wr = 1'b0;
      end
      alu8_pkg::OP_AND: begin
        r8 = a8 & b8;
        fo = {(r8 == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      alu8_pkg::OP_OR: begin
        r8 = a8 | b8;
        fo = {(r8 == 8'd0), 3'b000};
      end
      alu8_pkg::OP_XOR: begin
        r8 = a8 ^ b8;
        fo = {(r8 == 8'd0), 3'b000};
      end
      alu8_pkg::OP_INC: begin
        r8 = a8 + 8'd1;
        fo = {(r8 == 8'd0), 1'b0, (r8[3:0] == 4'd0), ci};
      end
      alu8_pkg::OP_DEC: begin
        r8 = a8 - 8'd1;
        fo = {(r8 == 8'd0), 1'b1, (a8[3:0] == 4'd0), ci};
      end
      alu8_pkg::OP_RLC: begin
        r8 = {a8[6:0], a8[7]};
        fo = {(r8 == 8'd0), 2'b00, a8[7]};
      end
      alu8_pkg::OP_RRC: begin
        r8 = {a8[0], a8[7:1]};
        fo = {(r8 == 8'd0), 2'b00, a8[0]};
      end
      alu8_pkg::OP_RL: begin
        r8 = {a8[6:0], ci};
        fo = {(r8 == 8'd0), 2'b00, a8[7]};
      end
      alu8_pkg::OP_RR: begin
        r8 = {ci, a8[7:1]};
        fo = {(r8 == 8'd0), 2'b00, a8[0]};
      end
      alu8_pkg::OP_SLA: begin
        r8 = {a8[6:0], 1'b0};
        fo = {(r8 == 8'd0), 2'b00, a8[7]};
      end
      alu8_pkg::OP_SRA: begin
        r8 = {a8[7], a8[7:1]};
        fo = {(r8 == 8'd0), 2'b00, a8[0]};
      end
      alu8_pkg::OP_SRL: begin
        r8 = {1'b0, a8[7:1]};
        fo = {(r8 == 8'd0), 2'b00, a8[0]};
      end
      alu8_pkg::OP_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        fo = {(r8 == 8'd0), 3'b000};
      end
      alu8_pkg::OP_BIT: begin
        fo = {((b8 & bit_mask) == 8'd0), 1'b0, 1'b1, ci};
        wr = 1'b0;
      end
      alu8_pkg::OP_RES: r8 = a8 & ~bit_mask;
      alu8_pkg::OP_SET: r8 = a8 | bit_mask;
      alu8_pkg::OP_DAA: begin
        r8 = ni ? (a8 - daa_adj) : (a8 + daa_adj);
        fo = {(r8 == 8'd0), ni, 1'b0, daa_c};
      end
      alu8_pkg::OP_CPL: begin
        r8 = ~a8;
        fo = {f[alu8_pkg::FLAG_Z], 1'b1, 1'b1, ci};
      end
      alu8_pkg::OP_CCF: begin
        fo = {f[alu8_pkg::FLAG_Z], 2'b00, ~ci};
        wr = 1'b0;
      end
      alu8_pkg::OP_SCF: begin
        fo = {f[alu8_pkg::FLAG_Z], 2'b00, 1'b1};
        wr = 1'b0;
      end
      alu8_pkg::OP_ADD16: begin
        r  = sum17[15:0];
        fo = {f[alu8_pkg::FLAG_Z], 1'b0, hsum13[12], sum17[16]};
      end
      alu8_pkg::OP_INC16: r = in_word.a_value + 16'd1;
      alu8_pkg::OP_DEC16: r = in_word.a_value - 16'd1;
      default: wr = 1'b0;
    endcase
    // Byte-wide operations leave the upper byte of the result clear.
    if (!((in_word.opcode == alu8_pkg::OP_ADD16) || (in_word.opcode == alu8_pkg::OP_INC16) ||
          (in_word.opcode == alu8_pkg::OP_DEC16))) begin
      r = {8'd0, r8};
    end
  end

  assign out_word.result        = r;
  assign out_word.flags_out     = fo;
  assign out_word.writes_result = wr;

endmodule
